// ----- design/fox_pkg.sv -----
// shared types, constants and fixed-point helpers of the field-oriented x-drive mixer
`timescale 1ns / 1ps
package fox_pkg;

	// configuration register indexes
	localparam logic REG_DEADBAND = 1'b0;
	localparam logic REG_MAX_PCT  = 1'b1;

	localparam logic [6:0] DEADBAND_RST = 7'd5;
	localparam logic [6:0] MAX_PCT_RST  = 7'd100;

	// stage counts of the trig lane and the mixing front end
	localparam int SIN_LAT = 8;
	localparam int MIX_LAT = 6;
	// quotient bits of the normalising divider, one cell per bit
	localparam int QUO_BITS = 16;

	// odd polynomial coefficients for the quarter sine wave, Q30
	localparam logic signed [32:0] SIN_C1 = 33'sd1686629713;
	localparam logic signed [32:0] SIN_C3 = 33'sd693598669;
	localparam logic signed [32:0] SIN_C5 = 33'sd85569305;
	localparam logic signed [32:0] SIN_C7 = 33'sd5026995;
	localparam logic signed [32:0] SIN_C9 = 33'sd172272;
	localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

	typedef struct packed {
		logic       coast;
		logic [3:0] neg;
	} fox_tag_t;

	// a * b in Q30, floor rounding
	function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
			input logic [30:0] b);
		logic signed [64:0] p;
		p = a * $signed({1'b0, b});
		return p[62:30];
	endfunction

endpackage

// ----- design/fox_sin.sv -----
// pipelined quarter-wave polynomial sine lane
`timescale 1ns / 1ps
module fox_sin #(
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [31:0]                       phase,
	output logic signed [TRIG_FRAC_BITS+1:0]  sine
);
	localparam int TF = TRIG_FRAC_BITS;
	localparam logic [30:0] RND = 31'(1) << (29 - TF);
	localparam logic signed [32:0] Q30_ONE_L = fox_pkg::Q30_ONE;

	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [30:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic signed [32:0] acc_s3, acc_s4, acc_s5, acc_s6, acc_s7;
	logic signed [TF+1:0] sine_s8;

	logic [30:0] x_fold;
	logic [61:0] sq;
	logic [30:0] clamped;
	logic [30:0] rsum;
	logic [TF:0] mag;

	always_comb begin
		// odd quadrants run the quarter wave backwards
		if (phase[30]) begin
			x_fold = 31'h4000_0000 - {1'b0, phase[29:0]};
		end else begin
			x_fold = {1'b0, phase[29:0]};
		end
		sq = x_s1 * x_s1;
		if (acc_s7 < 0) begin
			clamped = '0;
		end else if (acc_s7 > Q30_ONE_L) begin
			clamped = 31'h4000_0000;
		end else begin
			clamped = acc_s7[30:0];
		end
		rsum = clamped + RND;
		mag = rsum[30 -: TF+1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_fold;
			neg_s1  <= phase[31];
			x2_s2   <= sq[60:30];
			x_s2    <= x_s1;
			neg_s2  <= neg_s1;
			acc_s3  <= fox_pkg::mul_q30(fox_pkg::SIN_C9, x2_s2) - fox_pkg::SIN_C7;
			x2_s3   <= x2_s2;
			x_s3    <= x_s2;
			neg_s3  <= neg_s2;
			acc_s4  <= fox_pkg::mul_q30(acc_s3, x2_s3) + fox_pkg::SIN_C5;
			x2_s4   <= x2_s3;
			x_s4    <= x_s3;
			neg_s4  <= neg_s3;
			acc_s5  <= fox_pkg::mul_q30(acc_s4, x2_s4) - fox_pkg::SIN_C3;
			x2_s5   <= x2_s4;
			x_s5    <= x_s4;
			neg_s5  <= neg_s4;
			acc_s6  <= fox_pkg::mul_q30(acc_s5, x2_s5) + fox_pkg::SIN_C1;
			x_s6    <= x_s5;
			neg_s6  <= neg_s5;
			acc_s7  <= fox_pkg::mul_q30(acc_s6, x_s6);
			neg_s7  <= neg_s6;
			sine_s8 <= neg_s7 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign sine = sine_s8;

endmodule

// ----- design/fox_mix.sv -----
// frame rotation, wheel mixing, peak search and dividend set-up
`timescale 1ns / 1ps
module fox_mix #(
	parameter int TRIG_FRAC_BITS = 15,
	parameter int AW = 25,
	parameter int NW = 42
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [7:0]                 f,
	input  logic signed [7:0]                 s,
	input  logic signed [7:0]                 t,
	input  logic                              coast,
	input  logic signed [TRIG_FRAC_BITS+1:0]  sn,
	input  logic signed [TRIG_FRAC_BITS+1:0]  cs,
	input  logic [6:0]                        max_pct,
	output logic [3:0][NW-1:0]                num,
	output logic [AW:0]                       den2,
	output fox_pkg::fox_tag_t                 tag
);
	localparam int TF = TRIG_FRAC_BITS;
	localparam int PW = TF + 10;
	localparam int WW = TF + 11;
	localparam logic [AW-1:0] DEN_MIN = AW'(100 << TRIG_FRAC_BITS);

	logic signed [PW-1:0] fc_s1, ss_s1, fs_s1, sc_s1;
	logic signed [7:0]    t_s1, t_s2;
	logic                 coast_s1, coast_s2, coast_s3, coast_s4, coast_s5;
	logic signed [PW-1:0] fwd_s2, str_s2;
	logic signed [WW-1:0] w_s3 [4];
	logic [AW-1:0]        a_s4 [4];
	logic [AW-1:0]        a_s5 [4];
	logic [3:0]           neg_s4, neg_s5;
	logic [AW-1:0]        den_s5;
	logic [3:0][NW-1:0]   num_s6;
	logic [AW:0]          den2_s6;
	fox_pkg::fox_tag_t    tag_s6;

	logic signed [WW-1:0] tt, fw, st;
	logic signed [WW-1:0] w_n [4];
	logic [AW-1:0]        a_n [4];
	logic [AW-1:0]        pk01, pk23, pk;
	logic [AW+6:0]        mm [4];

	always_comb begin
		tt = WW'(t_s2) <<< TF;
		fw = WW'(fwd_s2);
		st = WW'(str_s2);
		w_n[0] = fw + st + tt;
		w_n[1] = fw - st - tt;
		w_n[2] = fw - st + tt;
		w_n[3] = fw + st - tt;
		for (int i = 0; i < 4; i++) begin
			a_n[i] = w_s3[i][WW-1] ? AW'(-w_s3[i]) : AW'(w_s3[i]);
			mm[i] = a_s5[i] * max_pct;
		end
		pk01 = (a_s4[0] > a_s4[1]) ? a_s4[0] : a_s4[1];
		pk23 = (a_s4[2] > a_s4[3]) ? a_s4[2] : a_s4[3];
		pk = (pk01 > pk23) ? pk01 : pk23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fc_s1    <= f * cs;
			ss_s1    <= s * sn;
			fs_s1    <= f * sn;
			sc_s1    <= s * cs;
			t_s1     <= t;
			coast_s1 <= coast;
			fwd_s2   <= fc_s1 + ss_s1;
			str_s2   <= sc_s1 - fs_s1;
			t_s2     <= t_s1;
			coast_s2 <= coast_s1;
			w_s3     <= w_n;
			coast_s3 <= coast_s2;
			a_s4     <= a_n;
			for (int i = 0; i < 4; i++) begin
				neg_s4[i] <= w_s3[i][WW-1];
			end
			coast_s4 <= coast_s3;
			a_s5     <= a_s4;
			neg_s5   <= neg_s4;
			den_s5   <= (pk > DEN_MIN) ? pk : DEN_MIN;
			coast_s5 <= coast_s4;
			// rounded quotient is (2*|v|*max*256 + den) / (2*den)
			for (int i = 0; i < 4; i++) begin
				num_s6[i] <= NW'({mm[i], 9'b0}) + NW'(den_s5);
			end
			den2_s6      <= {den_s5, 1'b0};
			tag_s6.coast <= coast_s5;
			tag_s6.neg   <= neg_s5;
		end
	end

	assign num  = num_s6;
	assign den2 = den2_s6;
	assign tag  = tag_s6;

endmodule

// ----- design/fox_div_cell.sv -----
// one restoring-division cell: settles one quotient bit for all four wheels
`timescale 1ns / 1ps
module fox_div_cell #(
	parameter int NW = 42,
	parameter int DW = 26,
	parameter int QB = 16,
	parameter int K  = 15
) (
	input  logic                clk,
	input  logic                en,
	input  logic [3:0][NW-1:0]  up_rem,
	input  logic [DW-1:0]       up_dvs,
	input  logic [3:0][QB-1:0]  up_quo,
	input  fox_pkg::fox_tag_t   up_tag,
	output logic [3:0][NW-1:0]  rem,
	output logic [DW-1:0]       dvs,
	output logic [3:0][QB-1:0]  quo,
	output fox_pkg::fox_tag_t   tag
);
	logic [NW-1:0]      dsh;
	logic [3:0][NW-1:0] rem_n;
	logic [3:0][QB-1:0] quo_n;
	logic [3:0][NW-1:0] rem_s1;
	logic [DW-1:0]      dvs_s1;
	logic [3:0][QB-1:0] quo_s1;
	fox_pkg::fox_tag_t  tag_s1;

	always_comb begin
		dsh = NW'(up_dvs) << K;
		for (int i = 0; i < 4; i++) begin
			rem_n[i] = up_rem[i];
			quo_n[i] = up_quo[i];
			if (up_rem[i] >= dsh) begin
				rem_n[i] = up_rem[i] - dsh;
				quo_n[i][K] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_n;
			dvs_s1 <= up_dvs;
			quo_s1 <= quo_n;
			tag_s1 <= up_tag;
		end
	end

	assign rem = rem_s1;
	assign dvs = dvs_s1;
	assign quo = quo_s1;
	assign tag = tag_s1;

endmodule

// ----- design/field_oriented_xdrive_mixer_unit.sv -----
// top level of the field-oriented x-drive wheel mixer
//
//  channel  dir  handshake          payload (lowest bit first)
//  s_*      in   s_tvalid/s_tready  forward, strafe, turn, heading
//  m_*      out  m_tvalid/m_tready  lf, rf, lb, rb; tuser coast_stop
//  cfg_*    in   cfg_we             index 0 deadband, 1 max percent
//
// one request enters per cycle while the output is not stalled; each result leaves through
// 8 trig stages, 6 mixing stages, 16 divider cells and the output register
// the 16-cell restoring divider is the longest part of the pipeline, one quotient bit per cell
// a stalled output freezes the whole pipeline; s_tready follows it
// reset clears valid flags and loads the register defaults
`timescale 1ns / 1ps
module field_oriented_xdrive_mixer_unit #(
	parameter int ANGLE_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // forward_cmd, strafe_cmd, turn_cmd, heading_angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // left_front, right_front, left_back, right_back
	output logic        m_tuser,   // coast_stop
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam int TF  = TRIG_FRAC_BITS;
	localparam int AW  = TF + 10;
	localparam int NW  = AW + 17;
	localparam int DW  = AW + 1;
	localparam int QB  = fox_pkg::QUO_BITS;
	localparam int SL  = fox_pkg::SIN_LAT;
	localparam int LAT = fox_pkg::SIN_LAT + fox_pkg::MIX_LAT + fox_pkg::QUO_BITS + 1;
	localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

	logic [6:0]     deadband_q, max_pct_q;
	logic [LAT-1:0] vld_q;
	logic           en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= fox_pkg::DEADBAND_RST;
			max_pct_q  <= fox_pkg::MAX_PCT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fox_pkg::REG_DEADBAND: deadband_q <= cfg_data;
				fox_pkg::REG_MAX_PCT:  max_pct_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// deadband and phase set-up
	logic signed [7:0] cmd [3];
	logic signed [7:0] cmd_db [3];
	logic [8:0]        cmag;
	logic [31:0]       ph_sin, ph_cos;
	logic              coast_n;

	always_comb begin
		cmd[0] = $signed(s_tdata[7:0]);
		cmd[1] = $signed(s_tdata[15:8]);
		cmd[2] = $signed(s_tdata[23:16]);
		for (int i = 0; i < 3; i++) begin
			cmag = cmd[i][7] ? 9'(-10'sd0 - 10'(cmd[i])) : 9'(cmd[i]);
			cmd_db[i] = (cmag < {2'b0, deadband_q}) ? 8'sd0 : cmd[i];
		end
		coast_n = (cmd_db[0] == 0) && (cmd_db[1] == 0) && (cmd_db[2] == 0);
		ph_sin = (({16'b0, s_tdata[39:24]}) & ANG_MASK) << (32 - ANGLE_BITS);
		ph_cos = ph_sin + 32'h4000_0000;
	end

	// commands wait alongside the trig lanes
	logic signed [7:0] f_q [SL];
	logic signed [7:0] s_q [SL];
	logic signed [7:0] t_q [SL];
	logic [SL-1:0]     coast_q;

	always_ff @(posedge clk) begin
		if (en) begin
			f_q[0]  <= cmd_db[0];
			s_q[0]  <= cmd_db[1];
			t_q[0]  <= cmd_db[2];
			for (int i = 1; i < SL; i++) begin
				f_q[i] <= f_q[i-1];
				s_q[i] <= s_q[i-1];
				t_q[i] <= t_q[i-1];
			end
			coast_q <= {coast_q[SL-2:0], coast_n};
		end
	end

	logic signed [TF+1:0] sn, cs;

	fox_sin #(.TRIG_FRAC_BITS(TF)) u_sin (
		.clk(clk), .en(en), .phase(ph_sin), .sine(sn)
	);

	fox_sin #(.TRIG_FRAC_BITS(TF)) u_cos (
		.clk(clk), .en(en), .phase(ph_cos), .sine(cs)
	);

	logic [3:0][NW-1:0] rem_c [QB+1];
	logic [DW-1:0]      dvs_c [QB+1];
	logic [3:0][QB-1:0] quo_c [QB+1];
	fox_pkg::fox_tag_t  tag_c [QB+1];

	fox_mix #(.TRIG_FRAC_BITS(TF), .AW(AW), .NW(NW)) u_mix (
		.clk(clk), .en(en),
		.f(f_q[SL-1]), .s(s_q[SL-1]), .t(t_q[SL-1]), .coast(coast_q[SL-1]),
		.sn(sn), .cs(cs), .max_pct(max_pct_q),
		.num(rem_c[0]), .den2(dvs_c[0]), .tag(tag_c[0])
	);

	assign quo_c[0] = '0;

	for (genvar g = 0; g < QB; g++) begin : g_cell
		fox_div_cell #(.NW(NW), .DW(DW), .QB(QB), .K(QB - 1 - g)) u_cell (
			.clk(clk), .en(en),
			.up_rem(rem_c[g]), .up_dvs(dvs_c[g]), .up_quo(quo_c[g]), .up_tag(tag_c[g]),
			.rem(rem_c[g+1]), .dvs(dvs_c[g+1]), .quo(quo_c[g+1]), .tag(tag_c[g+1])
		);
	end

	// sign back on, coast forces zero
	logic [63:0] out_n;
	logic [63:0] out_q;
	logic        coast_out_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (tag_c[QB].coast) begin
				out_n[16*i +: 16] = '0;
			end else if (tag_c[QB].neg[i]) begin
				out_n[16*i +: 16] = 16'(-quo_c[QB][i]);
			end else begin
				out_n[16*i +: 16] = 16'(quo_c[QB][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q       <= out_n;
			coast_out_q <= tag_c[QB].coast;
		end
	end

	assign m_tdata = out_q;
	assign m_tuser = coast_out_q;

endmodule

// ----- verif/tb_top.sv -----
// testbench for the field-oriented x-drive wheel mixer
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic signed [15:0] lf;
		logic signed [15:0] rf;
		logic signed [15:0] lb;
		logic signed [15:0] rb;
		logic               coast;
	} wheel_set_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // forward_cmd, strafe_cmd, turn_cmd, heading_angle
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // left_front, right_front, left_back, right_back
	logic        m_tuser;   // coast_stop
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	field_oriented_xdrive_mixer_unit u_top (.*);

	// predictor copy of the registers
	int unsigned deadband_q;
	int unsigned max_pct_q;

	wheel_set_t wheels_due[$];
	int     send_gap_pct;
	int     recv_gap_pct;
	bit     hold_off;
	int     errors;
	int     requests_sent;
	int     results_seen;
	int     coast_seen;
	int     idle_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint fshr30(longint v);
		return v >>> 30;
	endfunction

	function automatic longint sine_q(bit [31:0] ph);
		bit [1:0] quad;
		longint   x, x2, acc, mag;
		quad = ph[31:30];
		x = longint'(ph[29:0]);
		if (quad[0])
			x = 64'sd1073741824 - x;
		x2 = fshr30(x * x);
		acc = 172272;
		acc = -5026995 + fshr30(acc * x2);
		acc = 85569305 + fshr30(acc * x2);
		acc = -693598669 + fshr30(acc * x2);
		acc = 1686629713 + fshr30(acc * x2);
		acc = fshr30(acc * x);
		if (acc < 0)
			acc = 0;
		if (acc > 1073741824)
			acc = 1073741824;
		mag = (acc + (64'sd1 <<< 14)) >>> 15;
		return quad[1] ? -mag : mag;
	endfunction

	function automatic longint dead_zone(logic signed [7:0] c);
		longint v;
		v = longint'(c);
		return ((v < 0 ? -v : v) < longint'(deadband_q)) ? 0 : v;
	endfunction

	function automatic logic signed [15:0] wheel_scale(longint v, longint den);
		longint n, m, q;
		n = v * longint'(max_pct_q) * 256;
		m = n < 0 ? -n : n;
		q = (2 * m + den) / (2 * den);
		if (n < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic wheel_set_t mix_wheels(logic [39:0] d);
		longint     f, s, t, sn, cs, fwd, str, tt, den, a;
		longint     w[4];
		bit [31:0]  ph;
		wheel_set_t r;
		f = dead_zone(d[7:0]);
		s = dead_zone(d[15:8]);
		t = dead_zone(d[23:16]);
		r = '0;
		if (f == 0 && s == 0 && t == 0) begin
			r.coast = 1'b1;
			return r;
		end
		ph = {d[39:24], 16'h0};
		sn = sine_q(ph);
		cs = sine_q(ph + 32'h4000_0000);
		fwd = f * cs + s * sn;
		str = -f * sn + s * cs;
		tt = t <<< 15;
		w[0] = fwd + str + tt;
		w[1] = fwd - str - tt;
		w[2] = fwd - str + tt;
		w[3] = fwd + str - tt;
		den = 64'sd100 <<< 15;
		for (int i = 0; i < 4; i++) begin
			a = w[i] < 0 ? -w[i] : w[i];
			if (a > den)
				den = a;
		end
		r.lf = wheel_scale(w[0], den);
		r.rf = wheel_scale(w[1], den);
		r.lb = wheel_scale(w[2], den);
		r.rb = wheel_scale(w[3], den);
		return r;
	endfunction

	// s_tvalid stays up after the last request until the caller drains
	task automatic send_request(input logic signed [7:0] f, input logic signed [7:0] s,
			input logic signed [7:0] t, input logic [15:0] h);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {h, t, s, f};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		wheels_due.push_back(mix_wheels({h, t, s, f}));
		requests_sent++;
	endtask

	// receiver readiness
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// result checker
	always @(posedge clk) begin
		wheel_set_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (wheels_due.size() == 0) begin
				$error("result with nothing expected: %h %b", m_tdata, m_tuser);
				errors++;
			end else begin
				exp_w = wheels_due.pop_front();
				if (exp_w.coast) coast_seen++;
				if (m_tdata[15:0] !== exp_w.lf) begin
					$error("left_front_cmd exp %0d got %0d", exp_w.lf, $signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[31:16] !== exp_w.rf) begin
					$error("right_front_cmd exp %0d got %0d", exp_w.rf,
						$signed(m_tdata[31:16]));
					errors++;
				end
				if (m_tdata[47:32] !== exp_w.lb) begin
					$error("left_back_cmd exp %0d got %0d", exp_w.lb, $signed(m_tdata[47:32]));
					errors++;
				end
				if (m_tdata[63:48] !== exp_w.rb) begin
					$error("right_back_cmd exp %0d got %0d", exp_w.rb, $signed(m_tdata[63:48]));
					errors++;
				end
				if (m_tuser !== exp_w.coast) begin
					$error("coast_stop exp %0d got %0d", exp_w.coast, m_tuser);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake and no hold-off
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [6:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		if (idx == fox_pkg::REG_DEADBAND)
			deadband_q = val;
		else
			max_pct_q = val;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (wheels_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_burst(input int n);
		logic signed [7:0] f, s, t;
		for (int i = 0; i < n; i++) begin
			f = $urandom_range(99) < 85 ? 8'($signed($urandom_range(200)) - 100) : 8'($urandom);
			s = $urandom_range(99) < 85 ? 8'($signed($urandom_range(200)) - 100) : 8'($urandom);
			t = $urandom_range(99) < 85 ? 8'($signed($urandom_range(200)) - 100) : 8'($urandom);
			// some items with small sticks so the deadband bites
			if ($urandom_range(9) == 0) begin
				f = 8'($signed($urandom_range(8)) - 4);
				s = 8'($signed($urandom_range(8)) - 4);
				t = 8'($signed($urandom_range(8)) - 4);
			end
			send_request(f, s, t, 16'($urandom));
		end
	endtask

	task automatic test_directed();
		send_request(0, 0, 0, 16'h0000);
		send_request(4, -4, 4, 16'h1234);
		send_request(5, 0, 0, 16'h0000);
		send_request(100, 0, 0, 16'h0000);
		send_request(0, 100, 0, 16'h4000);
		send_request(0, 0, -100, 16'h8000);
		send_request(100, 100, 100, 16'h2000);
		send_request(-100, -100, -100, 16'hC000);
		send_request(127, 127, 127, 16'hFFFF);
		send_request(-128, -128, -128, 16'h6000);
		send_request(-128, 127, 0, 16'hA000);
		send_request(50, -50, 25, 16'hE000);
		send_request(1, 0, 0, 16'h5555);
		send_request(0, -6, 0, 16'hAAAA);
		drain_results();
	endtask

	task automatic test_register_sweep();
		write_reg(fox_pkg::REG_DEADBAND, 7'd0);
		write_reg(fox_pkg::REG_MAX_PCT, 7'd0);
		send_request(1, -1, 0, 16'h1000);
		send_request(0, 0, 0, 16'h0000);
		drain_results();
		write_reg(fox_pkg::REG_DEADBAND, 7'd127);
		write_reg(fox_pkg::REG_MAX_PCT, 7'd127);
		send_request(127, -128, 126, 16'h3000);
		send_request(-127, 100, 0, 16'h3000);
		random_burst(30);
		drain_results();
		write_reg(fox_pkg::REG_DEADBAND, 7'd100);
		write_reg(fox_pkg::REG_MAX_PCT, 7'd1);
		random_burst(30);
		drain_results();
	endtask

	task automatic test_random_mix();
		int plan[3][2] = '{'{6, 57}, '{57, 6}, '{0, 0}};
		for (int p = 0; p < 3; p++) begin
			send_gap_pct = plan[p][0];
			recv_gap_pct = plan[p][1];
			write_reg(fox_pkg::REG_DEADBAND, 7'($urandom_range(20)));
			write_reg(fox_pkg::REG_MAX_PCT, 7'($urandom_range(50, 127)));
			random_burst(320);
			drain_results();
		end
	endtask

	// output held off while the sender keeps pushing
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_burst(60);
		join
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fox_pkg::REG_DEADBAND;
		cfg_data = '0;
		hold_off = 1'b0;
		errors = 0;
		requests_sent = 0;
		results_seen = 0;
		coast_seen = 0;
		idle_cycles = 0;
		deadband_q = fox_pkg::DEADBAND_RST;
		max_pct_q = fox_pkg::MAX_PCT_RST;
		send_gap_pct = 6;
		recv_gap_pct = 57;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_backpressure();
		test_random_mix();
		if (wheels_due.size() != 0) begin
			$error("%0d results never arrived", wheels_due.size());
			errors++;
		end
		$display("requests %0d, results %0d (%0d coast stops), register extremes and stalls",
			requests_sent, results_seen, coast_seen);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
